// ===== rtl/pcp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcp_pkg
// shared types, constants and helpers for the polyline closest point block
// ----------------------------------------------------------------------------
package pcp_pkg;

  localparam int MAX_VERTICES  = 1024;
  localparam int SEG_INDEX_CAP = ((MAX_VERTICES - 1) > 1023) ? 1023 : (MAX_VERTICES - 1);
  localparam logic [10:0] COUNT_MAX = 11'd2047;

  // one classified vertex request handed from front to back
  typedef struct packed {
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [31:0] x1;
    logic signed [31:0] y1;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
    logic               seg;
    logic               last;
  } seg_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic signed [32:0] sub33(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return {a[31], a} - {b[31], b};
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

endpackage : pcp_pkg
`default_nettype wire

// ===== rtl/polyline_closest_point.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_closest_point
// closest point on a streamed polyline to a query point
// ----------------------------------------------------------------------------
// usage: vertices enter on the in_ channel (valid/stall), each with the query
// point and first/last flags; one result leaves on the out_ channel after each
// last-flagged vertex, found=0 when the polyline had no segment.
// a front part tracks the previous vertex and queues classified requests in a
// two-entry queue; the back part sequences one shared 33x33 multiplier.
// per vertex the back part clears the running state, or for a segment finds
// the distance directly if degenerate, after length and dot product if clamped,
// else after the 32-step restoring divider too; a last segment adds the square
// root, each last vertex the output; the divider and square root loops set the rate.
// the front keeps taking vertices while the queue has room, so input and
// output can stall on their own; a stalled result holds in the output register
// and the back part waits until it is taken.
// reset (rst_n low, synchronous) empties the queue, drops the open polyline
// and any pending result; no clearing pass is needed.
// ----------------------------------------------------------------------------
module polyline_closest_point (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_query_x,
  input  wire logic signed [31:0] in_query_y,
  input  wire logic signed [31:0] in_vertex_x,
  input  wire logic signed [31:0] in_vertex_y,
  input  wire logic               in_first_vertex,
  input  wire logic               in_last_vertex,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_found,
  output logic signed [31:0]      out_closest_x,
  output logic signed [31:0]      out_closest_y,
  output logic [32:0]             out_min_distance,
  output logic [9:0]              out_segment_index
);
  import pcp_pkg::*;

  logic     push, pop;
  seg_req_t push_data, head;
  q_stat_t  q_stat;

  pcp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_query_x      (in_query_x),
    .in_query_y      (in_query_y),
    .in_vertex_x     (in_vertex_x),
    .in_vertex_y     (in_vertex_y),
    .in_first_vertex (in_first_vertex),
    .in_last_vertex  (in_last_vertex),
    .q_stat          (q_stat),
    .push            (push),
    .push_data       (push_data)
  );

  pcp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  pcp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .q_stat            (q_stat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_closest_x     (out_closest_x),
    .out_closest_y     (out_closest_y),
    .out_min_distance  (out_min_distance),
    .out_segment_index (out_segment_index)
  );

endmodule : polyline_closest_point
`default_nettype wire

// ===== rtl/pcp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcp_queue
// two-entry request queue between the front and back parts
// ----------------------------------------------------------------------------
module pcp_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire pcp_pkg::seg_req_t push_data,
  input  wire logic              pop,
  output pcp_pkg::seg_req_t      head,
  output pcp_pkg::q_stat_t       stat
);
  import pcp_pkg::*;

  seg_req_t   mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = cnt_r == 2'd2;
  assign stat.empty = cnt_r == 2'd0;

endmodule : pcp_queue
`default_nettype wire

// ===== rtl/pcp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcp_front
// accepts vertices, tracks the previous vertex and classifies each request
// ----------------------------------------------------------------------------
module pcp_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_query_x,
  input  wire logic signed [31:0] in_query_y,
  input  wire logic signed [31:0] in_vertex_x,
  input  wire logic signed [31:0] in_vertex_y,
  input  wire logic               in_first_vertex,
  input  wire logic               in_last_vertex,
  input  wire pcp_pkg::q_stat_t   q_stat,
  output logic                    push,
  output pcp_pkg::seg_req_t       push_data
);
  import pcp_pkg::*;

  logic signed [31:0] prev_x_r, prev_y_r;
  logic               have_prev_r;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    push_data.qx   = in_query_x;
    push_data.qy   = in_query_y;
    push_data.x1   = prev_x_r;
    push_data.y1   = prev_y_r;
    push_data.x2   = in_vertex_x;
    push_data.y2   = in_vertex_y;
    // a first flag or no open polyline means clear instead of a segment
    push_data.seg  = have_prev_r && !in_first_vertex;
    push_data.last = in_last_vertex;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      have_prev_r <= 1'b0;
    end else if (push) begin
      prev_x_r    <= in_vertex_x;
      prev_y_r    <= in_vertex_y;
      have_prev_r <= !in_last_vertex;
    end
  end

endmodule : pcp_front
`default_nettype wire

// ===== rtl/pcp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pcp_back
// sequenced projection, distance, running minimum and square root
// ----------------------------------------------------------------------------
module pcp_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pcp_pkg::seg_req_t head,
  input  wire pcp_pkg::q_stat_t  q_stat,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_found,
  output logic signed [31:0]     out_closest_x,
  output logic signed [31:0]     out_closest_y,
  output logic [32:0]            out_min_distance,
  output logic [9:0]             out_segment_index
);
  import pcp_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_M0   = 4'd1;
  localparam logic [3:0] ST_M1   = 4'd2;
  localparam logic [3:0] ST_M2   = 4'd3;
  localparam logic [3:0] ST_M3   = 4'd4;
  localparam logic [3:0] ST_M4   = 4'd5;
  localparam logic [3:0] ST_CMP  = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_P0   = 4'd8;
  localparam logic [3:0] ST_P1   = 4'd9;
  localparam logic [3:0] ST_P2   = 4'd10;
  localparam logic [3:0] ST_D0   = 4'd11;
  localparam logic [3:0] ST_D1   = 4'd12;
  localparam logic [3:0] ST_D2   = 4'd13;
  localparam logic [3:0] ST_SQ   = 4'd14;
  localparam logic [3:0] ST_OUT  = 4'd15;

  localparam logic [9:0] IDX_CAP = 10'(SEG_INDEX_CAP);

  logic [3:0]          state_r;
  seg_req_t            cur_r;
  logic [65:0]         prod_r;
  logic [66:0]         len_r;
  logic signed [67:0]  dot_r;
  logic [67:0]         rem_r;
  logic [31:0]         t_r;
  logic [4:0]          div_cnt_r;
  logic signed [31:0]  px_r, py_r;
  logic [63:0]         ex2_r;
  logic [63:0]         best_d_r;
  logic signed [31:0]  best_x_r, best_y_r;
  logic [9:0]          best_idx_r;
  logic [10:0]         seg_cnt_r;
  logic [63:0]         sq_v_r, sq_res_r, sq_bit_r;
  logic                out_valid_r, out_found_r;
  logic signed [31:0]  out_x_r, out_y_r;
  logic [32:0]         out_dist_r;
  logic [9:0]          out_idx_r;

  logic signed [32:0]  dx, dy, ax, ay;
  logic [32:0]         mul_a, mul_b;
  logic [67:0]         sp, rem_sh;
  logic [64:0]         dsum, sq_try;
  logic [63:0]         d_sat;
  logic                take;
  logic [9:0]          idx_now;

  assign dx = sub33(cur_r.x2, cur_r.x1);
  assign dy = sub33(cur_r.y2, cur_r.y1);
  assign ax = sub33(cur_r.qx, cur_r.x1);
  assign ay = sub33(cur_r.qy, cur_r.y1);

  function automatic logic signed [31:0] step_along(input logic signed [31:0] start,
                                                    input logic neg,
                                                    input logic [32:0] off);
    logic signed [33:0] s;
    logic signed [33:0] r;
    s = {{2{start[31]}}, start};
    r = neg ? s - {1'b0, off} : s + {1'b0, off};
    return r[31:0];
  endfunction

  // one shared multiplier, operands chosen by the sequencer
  always_comb begin
    unique case (state_r)
      ST_M0:   begin mul_a = mag33(dx); mul_b = mag33(dx); end
      ST_M1:   begin mul_a = mag33(dy); mul_b = mag33(dy); end
      ST_M2:   begin mul_a = mag33(ax); mul_b = mag33(dx); end
      ST_M3:   begin mul_a = mag33(ay); mul_b = mag33(dy); end
      ST_P0:   begin mul_a = {1'b0, t_r}; mul_b = mag33(dx); end
      ST_P1:   begin mul_a = {1'b0, t_r}; mul_b = mag33(dy); end
      ST_D0:   begin
        mul_a = mag33(sub33(cur_r.qx, px_r));
        mul_b = mul_a;
      end
      ST_D1:   begin
        mul_a = mag33(sub33(cur_r.qy, py_r));
        mul_b = mul_a;
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign sp     = {2'b00, prod_r};
  assign rem_sh = {rem_r[66:0], 1'b0};
  assign dsum   = {1'b0, ex2_r} + {1'b0, prod_r[63:0]};
  assign d_sat  = dsum[64] ? '1 : dsum[63:0];
  assign take   = (seg_cnt_r == 11'd0) || (d_sat < best_d_r);
  assign idx_now = (seg_cnt_r > 11'(SEG_INDEX_CAP)) ? IDX_CAP : seg_cnt_r[9:0];
  assign sq_try = {1'b0, sq_res_r} + {1'b0, sq_bit_r};

  assign pop = (state_r == ST_IDLE) && !q_stat.empty;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      best_d_r    <= '1;
      best_x_r    <= '0;
      best_y_r    <= '0;
      best_idx_r  <= '0;
      seg_cnt_r   <= '0;
    end else begin
      // the output state reloads the result register itself
      if (out_valid_r && !out_stall && state_r != ST_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            cur_r <= head;
            if (head.seg) begin
              state_r <= ST_M0;
            end else begin
              best_d_r   <= '1;
              best_x_r   <= '0;
              best_y_r   <= '0;
              best_idx_r <= '0;
              seg_cnt_r  <= '0;
              state_r    <= head.last ? ST_OUT : ST_IDLE;
            end
          end
        end
        ST_M0: begin
          if (dx == '0 && dy == '0) begin
            // degenerate segment projects to its start
            px_r    <= cur_r.x1;
            py_r    <= cur_r.y1;
            state_r <= ST_D0;
          end else begin
            state_r <= ST_M1;
          end
        end
        ST_M1: begin
          len_r   <= {1'b0, prod_r};
          state_r <= ST_M2;
        end
        ST_M2: begin
          len_r   <= len_r + {1'b0, prod_r};
          state_r <= ST_M3;
        end
        ST_M3: begin
          dot_r   <= (ax[32] ^ dx[32]) ? -$signed(sp) : $signed(sp);
          state_r <= ST_M4;
        end
        ST_M4: begin
          dot_r   <= dot_r + ((ay[32] ^ dy[32]) ? -$signed(sp) : $signed(sp));
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          priority if (dot_r[67] || dot_r == '0) begin
            px_r    <= cur_r.x1;
            py_r    <= cur_r.y1;
            state_r <= ST_D0;
          end else if (dot_r[66:0] >= len_r) begin
            px_r    <= cur_r.x2;
            py_r    <= cur_r.y2;
            state_r <= ST_D0;
          end else begin
            rem_r     <= dot_r;
            t_r       <= '0;
            div_cnt_r <= '0;
            state_r   <= ST_DIV;
          end
        end
        ST_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (rem_sh >= {1'b0, len_r}) begin
            rem_r <= rem_sh - {1'b0, len_r};
            t_r   <= {t_r[30:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            t_r   <= {t_r[30:0], 1'b0};
          end
          div_cnt_r <= div_cnt_r + 5'd1;
          if (div_cnt_r == 5'd31) state_r <= ST_P0;
        end
        ST_P0: state_r <= ST_P1;
        ST_P1: begin
          px_r    <= step_along(cur_r.x1, dx[32], prod_r[64:32]);
          state_r <= ST_P2;
        end
        ST_P2: begin
          py_r    <= step_along(cur_r.y1, dy[32], prod_r[64:32]);
          state_r <= ST_D0;
        end
        ST_D0: state_r <= ST_D1;
        ST_D1: begin
          ex2_r   <= prod_r[63:0];
          state_r <= ST_D2;
        end
        ST_D2: begin
          if (take) begin
            best_d_r   <= d_sat;
            best_x_r   <= px_r;
            best_y_r   <= py_r;
            best_idx_r <= idx_now;
          end
          if (seg_cnt_r < COUNT_MAX) seg_cnt_r <= seg_cnt_r + 11'd1;
          sq_v_r   <= take ? d_sat : best_d_r;
          sq_res_r <= '0;
          sq_bit_r <= 64'd1 << 62;
          state_r  <= cur_r.last ? ST_SQ : ST_IDLE;
        end
        ST_SQ: begin
          if (sq_bit_r == '0) begin
            state_r <= ST_OUT;
          end else begin
            if ({1'b0, sq_v_r} >= sq_try) begin
              sq_v_r   <= sq_v_r - sq_try[63:0];
              sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
            end else begin
              sq_res_r <= sq_res_r >> 1;
            end
            sq_bit_r <= sq_bit_r >> 2;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_found_r <= seg_cnt_r != 11'd0;
            out_x_r     <= best_x_r;
            out_y_r     <= best_y_r;
            out_idx_r   <= best_idx_r;
            out_dist_r  <= (seg_cnt_r != 11'd0) ? {1'b0, sq_res_r[31:0]} : '1;
            best_d_r    <= '1;
            best_x_r    <= '0;
            best_y_r    <= '0;
            best_idx_r  <= '0;
            seg_cnt_r   <= '0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_closest_x     = out_x_r;
  assign out_closest_y     = out_y_r;
  assign out_min_distance  = out_dist_r;
  assign out_segment_index = out_idx_r;

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < {1'b0, len_r}))
    else $error("divider remainder not below divisor");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_OUT))
    else $error("result raised outside output state");

  a_idx_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (seg_cnt_r != 11'd0) |-> ({1'b0, best_idx_r} < seg_cnt_r))
    else $error("best index beyond segment count");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r != ST_IDLE || !$past(head.seg)))
    else $error("segment request popped without starting work");

endmodule : pcp_back
`default_nettype wire

// ===== tb/sv/pcp_checker.sv =====
// ----------------------------------------------------------------------------
// pcp_checker
// watches both channels of the polyline closest point block, predicts each
// result from the accepted vertex requests and compares field by field
// ----------------------------------------------------------------------------
module pcp_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic signed [31:0] in_query_x,
  input  wire logic signed [31:0] in_query_y,
  input  wire logic signed [31:0] in_vertex_x,
  input  wire logic signed [31:0] in_vertex_y,
  input  wire logic               in_first_vertex,
  input  wire logic               in_last_vertex,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic               out_found,
  input  wire logic signed [31:0] out_closest_x,
  input  wire logic signed [31:0] out_closest_y,
  input  wire logic [32:0]        out_min_distance,
  input  wire logic [9:0]         out_segment_index,
  output int                      outstanding,
  output int                      fail_count
);
  import pcp_pkg::*;

  typedef struct {
    logic        found;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [32:0] distance;
    logic [9:0]  idx;
  } closest_t;

  closest_t pending_results[$];

  // running state of the open polyline
  longint          last_x, last_y;
  bit              open_run;
  longint unsigned best_sq;
  longint          best_x, best_y;
  int              best_idx, seg_cnt;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint slide(input longint start, input longint d,
                                   input logic [31:0] t);
    logic [127:0] p;
    longint       off;
    p   = 128'(t) * 128'(d < 0 ? -d : d);
    off = longint'(p[95:32]);
    return d < 0 ? start - off : start + off;
  endfunction

  function automatic void reset_run();
    open_run = 0;
    best_sq  = '1;
    best_x   = 0;
    best_y   = 0;
    best_idx = 0;
    seg_cnt  = 0;
  endfunction

  function automatic void project_segment(input longint qx, input longint qy,
                                          input longint x2, input longint y2);
    logic signed [127:0] dxw, dyw, len, dot, tq;
    longint              px, py, dx, dy;
    longint unsigned     ex, ey, d;
    dx  = x2 - last_x;
    dy  = y2 - last_y;
    px  = last_x;
    py  = last_y;
    if (dx != 0 || dy != 0) begin
      dxw = dx;
      dyw = dy;
      len = dxw * dxw + dyw * dyw;
      dot = (128'(signed'(qx - last_x))) * dxw + (128'(signed'(qy - last_y))) * dyw;
      if (dot >= len) begin
        px = x2;
        py = y2;
      end else if (dot > 0) begin
        tq = (dot <<< 32) / len;
        px = slide(last_x, dx, tq[31:0]);
        py = slide(last_y, dy, tq[31:0]);
      end
    end
    ex = (qx - px) < 0 ? px - qx : qx - px;
    ey = (qy - py) < 0 ? py - qy : qy - py;
    ex = ex * ex;
    ey = ey * ey;
    d  = ex + ey;
    if (d < ex) d = '1;
    if (seg_cnt == 0 || d < best_sq) begin
      best_sq  = d;
      best_x   = px;
      best_y   = py;
      best_idx = seg_cnt > SEG_INDEX_CAP ? SEG_INDEX_CAP : seg_cnt;
    end
    if (seg_cnt < int'(COUNT_MAX)) seg_cnt++;
  endfunction

  function automatic void take_vertex();
    closest_t r;
    if (in_first_vertex || !open_run)
      reset_run();
    else
      project_segment(in_query_x, in_query_y, in_vertex_x, in_vertex_y);
    last_x   = in_vertex_x;
    last_y   = in_vertex_y;
    open_run = 1;
    if (in_last_vertex) begin
      if (seg_cnt != 0) begin
        r.found    = 1;
        r.cx       = best_x[31:0];
        r.cy       = best_y[31:0];
        r.distance = 33'(int_sqrt(best_sq));
        r.idx      = 10'(best_idx);
      end else begin
        r.found    = 0;
        r.cx       = '0;
        r.cy       = '0;
        r.distance = '1;
        r.idx      = '0;
      end
      pending_results.push_back(r);
      reset_run();
    end
  endfunction

  initial begin
    last_x      = 0;
    last_y      = 0;
    fail_count  = 0;
    outstanding = 0;
    reset_run();
  end

  always @(posedge clk) begin
    closest_t e;
    if (rst_n) begin
      if (in_valid && !in_stall) take_vertex();
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result found=%0d x=%h y=%h", $time, out_found,
                   out_closest_x, out_closest_y);
          fail_count++;
        end else begin
          e = pending_results.pop_front();
          if (out_found !== e.found || out_closest_x !== e.cx || out_closest_y !== e.cy ||
              out_min_distance !== e.distance || out_segment_index !== e.idx) begin
            $display("%0t: mismatch expected found=%0d x=%h y=%h dist=%h idx=%0d", $time,
                     e.found, e.cx, e.cy, e.distance, e.idx);
            $display("%0t:          actual   found=%0d x=%h y=%h dist=%h idx=%0d", $time,
                     out_found, out_closest_x, out_closest_y, out_min_distance,
                     out_segment_index);
            fail_count++;
          end
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives polylines into the closest point block with bursty requests and a
// stalling receiver; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 1500000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_query_x, in_query_y, in_vertex_x, in_vertex_y;
  logic               in_first_vertex, in_last_vertex;
  logic               out_valid, out_stall, out_found;
  logic signed [31:0] out_closest_x, out_closest_y;
  logic [32:0]        out_min_distance;
  logic [9:0]         out_segment_index;
  int                 outstanding, fail_count;
  int                 burst_left, cycles, stall_mode;

  polyline_closest_point u_top (.*);

  pcp_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stalls on its own pattern: free, light or heavy
  always @(posedge clk) begin
    if (cycles % 97 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  function automatic logic [31:0] pick_coord(input int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h001f_ffff)) - 32'h0010_0000);
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(0, 7) - 4;
    endcase
  endfunction

  task automatic send_vertex(input logic [31:0] qx, input logic [31:0] qy,
                             input logic [31:0] vx, input logic [31:0] vy,
                             input logic first, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_query_x      <= qx;
    in_query_y      <= qy;
    in_vertex_x     <= vx;
    in_vertex_y     <= vy;
    in_first_vertex <= first;
    in_last_vertex  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_polyline(input int n, input int kind);
    logic [31:0] qx, qy;
    qx = pick_coord(kind);
    qy = pick_coord(kind);
    for (int i = 0; i < n; i++)
      send_vertex(qx, qy, pick_coord(kind), pick_coord(kind), i == 0, i == n - 1);
  endtask

  initial begin
    rst_n           = 0;
    in_valid        = 0;
    in_query_x      = 0;
    in_query_y      = 0;
    in_vertex_x     = 0;
    in_vertex_y     = 0;
    in_first_vertex = 0;
    in_last_vertex  = 0;
    out_stall       = 0;
    stall_mode      = 0;
    cycles          = 0;
    burst_left      = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no first flag while idle opens a polyline
    send_vertex(0, 0, 32'h0001_0000, 0, 0, 0);
    send_vertex(0, 32'h0001_0000, 32'h0003_0000, 0, 0, 1);
    // single vertex with both flags
    send_vertex(5, 5, 7, 7, 1, 1);
    // extremes, interior projection, degenerate segment, clamp to the start
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1, 0);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0, 0);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0, 0);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0, 1);
    // tie between two segments meeting at the closest vertex
    send_vertex(0, 32'h0002_0000, 32'hfffe_0000, 0, 1, 0);
    send_vertex(0, 32'h0002_0000, 0, 32'h0001_0000, 0, 0);
    send_vertex(0, 32'h0002_0000, 32'h0002_0000, 0, 0, 1);
    // interior projection with odd slope
    send_vertex(32'h0000_1234, 32'h0005_0000, 32'hfff0_0001, 32'h0000_0003, 1, 0);
    send_vertex(32'h0000_1234, 32'h0005_0000, 32'h0013_5555, 32'h0007_aaab, 0, 1);
    // query far from tiny segment so the squared distance saturates
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_fffe, 1, 0);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h7fff_fffe, 32'h7fff_ffff, 0, 1);

    for (int n = 0; n < 435; ) begin
      if ($urandom_range(0, 9) < 8) begin
        automatic int len = $urandom_range(0, 9) == 0 ? $urandom_range(1, 3)
                                                     : $urandom_range(2, 10);
        send_polyline(len, $urandom_range(0, 3));
        n += len;
      end else begin
        // broken sequences: random flags and coordinates
        send_vertex(pick_coord(0), pick_coord(0), pick_coord(1), pick_coord(1),
                    $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
        n++;
      end
    end
    send_vertex(0, 0, 0, 0, 0, 1);
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pcp_pkg.sv
rtl/pcp_queue.sv
rtl/pcp_front.sv
rtl/pcp_back.sv
rtl/polyline_closest_point.sv
tb/sv/pcp_checker.sv
tb/sv/testbench.sv
